FILE: hw/rtl/smax_pkg.sv
// Shared types and constants for the stack with running maximum.
// Used by smax_ctrl, smax_dp and the top level stack_with_running_maximum.
// No dependencies.
package smax_pkg;

  // Stack geometry.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the stream beats.
  localparam int DATA_W  = 32;
  localparam int FILL_W  = 7;
  localparam int STAT_W  = 2;
  localparam int OUT_W   = 3 * DATA_W + 1 + FILL_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

  // Operation codes carried on in_tuser.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Status codes carried on out_tuser.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // An input beat is taken this cycle.
    logic rd_issue;  // Read the new top entries from the memories.
    logic load;      // Capture the read data into the cached top and maximum.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // No values held.
    logic full;      // DEPTH values held.
    logic last_one;  // Exactly one value held.
  } dp_stat_t;

endpackage

FILE: hw/rtl/stack_with_running_maximum.sv
// Stack with running maximum: LIFO of signed 32-bit values with max tracking.
// A push, a refused operation or an emptying pop shows its result in the cycle after acceptance;
// a pop that leaves values behind passes first through the registered memory read and the reload.
// A new operation is taken only once the result beat of the previous one has been accepted.
// Reset: synchronous, active low; empties the stack. Memory contents are not cleared.
// Depends on smax_pkg, smax_ctrl and smax_dp.
module stack_with_running_maximum (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [smax_pkg::DATA_W-1:0]        in_tdata,   // [31:0] value
  input  logic                               in_tuser,   // [0] mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smax_pkg::OUT_PAD-1:0]       out_tdata,  // [31:0] popped_value, [63:32] top_value,
                                                         // [95:64] max_value, [96] is_empty,
                                                         // [103:97] fill_count
  output logic [smax_pkg::STAT_W-1:0]        out_tuser   // [1:0] status
);

  smax_pkg::dp_cmd_t                  cmd;
  smax_pkg::dp_stat_t                 stat;
  logic signed [smax_pkg::DATA_W-1:0] popped_value;
  logic signed [smax_pkg::DATA_W-1:0] top_value;
  logic signed [smax_pkg::DATA_W-1:0] max_value;
  logic                               is_empty;
  logic        [smax_pkg::FILL_W-1:0] fill_count;
  logic        [smax_pkg::STAT_W-1:0] status;

  smax_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  smax_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_mode      (in_tuser),
    .in_value     ($signed(in_tdata)),
    .stat         (stat),
    .popped_value (popped_value),
    .top_value    (top_value),
    .max_value    (max_value),
    .is_empty     (is_empty),
    .fill_count   (fill_count),
    .status       (status)
  );

  // Pack the result beat; popped_value sits in the lowest bits, fill_count in the highest.
  assign out_tdata = smax_pkg::OUT_PAD'({fill_count, is_empty, max_value, top_value, popped_value});
  assign out_tuser = status;

endmodule

FILE: hw/rtl/smax_ctrl.sv
// Controller state machine of the stack with running maximum.
// Sequences accept, memory read, reload and result beat.
// Depends on smax_pkg.
module smax_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_mode,
  input  logic                out_tready,
  input  smax_pkg::dp_stat_t  stat,
  output logic                in_tready,
  output logic                out_tvalid,
  output smax_pkg::dp_cmd_t   cmd
);

  smax_pkg::state_t state_r;
  smax_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smax_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state. Only a pop that leaves values behind needs a memory read.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smax_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if ((in_mode == smax_pkg::MODE_POP) && !stat.empty && !stat.last_one) begin
            state_nxt = smax_pkg::S_READ;
          end else begin
            state_nxt = smax_pkg::S_OUT;
          end
        end
      end
      smax_pkg::S_READ: state_nxt = smax_pkg::S_LOAD;
      smax_pkg::S_LOAD: state_nxt = smax_pkg::S_OUT;
      smax_pkg::S_OUT: begin
        if (out_tready) begin
          state_nxt = smax_pkg::S_IDLE;
        end
      end
      default: state_nxt = smax_pkg::S_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    in_tready    = (state_r == smax_pkg::S_IDLE);
    out_tvalid   = (state_r == smax_pkg::S_OUT);
    cmd.accept   = (state_r == smax_pkg::S_IDLE) && in_tvalid;
    cmd.rd_issue = (state_r == smax_pkg::S_READ);
    cmd.load     = (state_r == smax_pkg::S_LOAD);
  end

  // The input and output sides are never open in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input and output handshakes open together");

  // A reload is always followed by the result beat.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> out_tvalid)
    else $error("reload not followed by result beat");

  // A memory read is always followed by the reload.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.rd_issue |=> cmd.load)
    else $error("memory read not followed by reload");

endmodule

FILE: hw/rtl/smax_dp.sv
// Datapath of the stack with running maximum: value and maxima memories,
// counts, cached top and maximum, and the result registers.
// Depends on smax_pkg.
module smax_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smax_pkg::dp_cmd_t                    cmd,
  input  logic                                 in_mode,
  input  logic signed [smax_pkg::DATA_W-1:0]   in_value,
  output smax_pkg::dp_stat_t                   stat,
  output logic signed [smax_pkg::DATA_W-1:0]   popped_value,
  output logic signed [smax_pkg::DATA_W-1:0]   top_value,
  output logic signed [smax_pkg::DATA_W-1:0]   max_value,
  output logic                                 is_empty,
  output logic        [smax_pkg::FILL_W-1:0]   fill_count,
  output logic        [smax_pkg::STAT_W-1:0]   status
);

  // Each value entry carries its maximum mark in the top bit.
  logic [smax_pkg::DATA_W:0]   vmem [smax_pkg::DEPTH];
  logic [smax_pkg::DATA_W-1:0] mmem [smax_pkg::DEPTH];

  logic [smax_pkg::CNT_W-1:0]         count_r;
  logic [smax_pkg::CNT_W-1:0]         mcount_r;
  logic signed [smax_pkg::DATA_W-1:0] top_r;
  logic                               top_mark_r;
  logic signed [smax_pkg::DATA_W-1:0] max_r;
  logic                               pop_mark_r;
  logic signed [smax_pkg::DATA_W-1:0] popped_r;
  logic [smax_pkg::STAT_W-1:0]        status_r;
  logic [smax_pkg::DATA_W:0]          vrd_r;
  logic [smax_pkg::DATA_W-1:0]        mrd_r;

  logic                               do_push;
  logic                               do_pop;
  logic                               rec;
  logic [smax_pkg::CNT_W-1:0]         count_dec;
  logic [smax_pkg::CNT_W-1:0]         mcount_dec;

  // Status toward the controller.
  always_comb begin
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == smax_pkg::CNT_W'(smax_pkg::DEPTH));
    stat.last_one = (count_r == smax_pkg::CNT_W'(1));
  end

  // Operation decode; a value becomes a new maximum on an empty stack or when strictly greater.
  always_comb begin
    do_push    = cmd.accept && (in_mode == smax_pkg::MODE_PUSH) && !stat.full;
    do_pop     = cmd.accept && (in_mode == smax_pkg::MODE_POP) && !stat.empty;
    rec        = stat.empty || (in_value > max_r);
    count_dec  = count_r - smax_pkg::CNT_W'(1);
    mcount_dec = mcount_r - smax_pkg::CNT_W'(1);
  end

  // Counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      mcount_r <= '0;
    end else if (do_push) begin
      count_r  <= count_r + smax_pkg::CNT_W'(1);
      mcount_r <= mcount_r + smax_pkg::CNT_W'(rec);
    end else if (do_pop) begin
      count_r  <= count_dec;
      mcount_r <= mcount_r - smax_pkg::CNT_W'(top_mark_r);
    end
  end

  // Memory writes on a push.
  always_ff @(posedge clk) begin
    if (do_push) begin
      vmem[count_r[smax_pkg::ADDR_W-1:0]] <= {rec, in_value};
      if (rec) begin
        mmem[mcount_r[smax_pkg::ADDR_W-1:0]] <= in_value;
      end
    end
  end

  // Registered memory reads of the new tops after a pop.
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      vrd_r <= vmem[count_dec[smax_pkg::ADDR_W-1:0]];
      mrd_r <= mmem[mcount_dec[smax_pkg::ADDR_W-1:0]];
    end
  end

  // Cached top entry and current maximum.
  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r      <= in_value;
      top_mark_r <= rec;
      if (rec) begin
        max_r <= in_value;
      end
    end else if (cmd.load) begin
      top_r      <= $signed(vrd_r[smax_pkg::DATA_W-1:0]);
      top_mark_r <= vrd_r[smax_pkg::DATA_W];
      if (pop_mark_r) begin
        max_r <= $signed(mrd_r);
      end
    end
  end

  // Result registers, set when a beat is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_mark_r <= top_mark_r;
      popped_r   <= do_pop ? top_r : '0;
      if (in_mode == smax_pkg::MODE_PUSH) begin
        status_r <= stat.full ? smax_pkg::ST_FULL : smax_pkg::ST_OK;
      end else begin
        status_r <= stat.empty ? smax_pkg::ST_EMPTY : smax_pkg::ST_OK;
      end
    end
  end

  // Result fields; top and maximum read as zero on an empty stack.
  always_comb begin
    popped_value = popped_r;
    top_value    = stat.empty ? '0 : top_r;
    max_value    = stat.empty ? '0 : max_r;
    is_empty     = stat.empty;
    fill_count   = smax_pkg::FILL_W'(count_r);
    status       = status_r;
  end

  // The maxima stack never holds more entries than the value stack.
  assert property (@(posedge clk) disable iff (!rst_n) mcount_r <= count_r)
    else $error("maxima count exceeds value count");

  // The count never passes the depth.
  assert property (@(posedge clk) disable iff (!rst_n)
                   count_r <= smax_pkg::CNT_W'(smax_pkg::DEPTH))
    else $error("value count beyond depth");

  // A non-empty stack always has at least one recorded maximum.
  assert property (@(posedge clk) disable iff (!rst_n) (count_r != '0) |-> (mcount_r != '0))
    else $error("values held without a recorded maximum");

endmodule

FILE: dv/stack_with_running_maximum_tb.sv
// Self-checking testbench for stack_with_running_maximum: directed table, then push/pop bursts.
// Results are predicted by a behavioral stack with a maxima history, or taken from the table
// for typed rows, and compared beat by beat. Depends on smax_pkg and the stack_with_running_maximum RTL.
`timescale 1ns / 100ps

module stack_with_running_maximum_tb;

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1525;
  localparam int N_ROWS       = 24;

  // Everything one result beat reports.
  typedef struct packed {
    logic [smax_pkg::DATA_W-1:0] popped;
    logic [smax_pkg::DATA_W-1:0] top;
    logic [smax_pkg::DATA_W-1:0] maxv;
    logic                        empty;
    logic [smax_pkg::FILL_W-1:0] fill;
    logic [smax_pkg::STAT_W-1:0] status;
  } stack_view_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic                        mode;
    logic [smax_pkg::DATA_W-1:0] value;
    logic                        typed;
    stack_view_t                 want;
  } stim_row_t;

  localparam stack_view_t NO_VIEW = '0;

  // Directed walk: extremes, equal maxima, draining to empty and refused pops.
  localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b1,
      '{32'h0, 32'h0, 32'h0, 1'b1, 7'd0, smax_pkg::ST_EMPTY}},
    '{smax_pkg::MODE_PUSH, 32'h8000_0000, 1'b1,
      '{32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 7'd1, smax_pkg::ST_OK}},
    '{smax_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b1,
      '{32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 7'd2, smax_pkg::ST_OK}},
    '{smax_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'hA5A5_A5A5, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'h5A5A_5A5A, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'hFFFF_FFFF, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b1,
      '{32'h8000_0000, 32'h0, 32'h0, 1'b1, 7'd0, smax_pkg::ST_OK}},
    '{smax_pkg::MODE_POP,  32'h1234_5678, 1'b1,
      '{32'h0, 32'h0, 32'h0, 1'b1, 7'd0, smax_pkg::ST_EMPTY}},
    '{smax_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 7'd1, smax_pkg::ST_OK}},
    '{smax_pkg::MODE_PUSH, 32'hFFFF_FFFE, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'h0000_0001, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_PUSH, 32'h0000_0001, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW},
    '{smax_pkg::MODE_POP,  32'h0000_0000, 1'b0, NO_VIEW}
  };

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [smax_pkg::DATA_W-1:0]   in_tdata   = '0;
  logic                          in_tuser   = smax_pkg::MODE_PUSH;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [smax_pkg::OUT_PAD-1:0]  out_tdata;
  logic [smax_pkg::STAT_W-1:0]   out_tuser;

  // Behavioral copy of the stack and its maxima history.
  logic [smax_pkg::DATA_W-1:0]   stk_vals [smax_pkg::DEPTH];
  logic                          stk_marks [smax_pkg::DEPTH];
  logic [smax_pkg::DATA_W-1:0]   max_hist [smax_pkg::DEPTH];
  int                            n_vals = 0;
  int                            n_max  = 0;

  stack_view_t         pending_views [$];
  int                  idle_pct = 20;
  int                  mismatches = 0;
  int                  n_push = 0;
  int                  n_pop = 0;
  int                  n_full = 0;
  int                  n_empty = 0;
  int                  n_checked = 0;
  int                  peak_fill = 0;

  stack_with_running_maximum u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one operation to the behavioral stack and return the view it reports.
  function automatic stack_view_t apply_stack_op(logic mode,
                                                 logic [smax_pkg::DATA_W-1:0] value);
    stack_view_t v;
    logic        record;
    v = '0;
    v.status = smax_pkg::ST_OK;
    if (mode == smax_pkg::MODE_PUSH) begin
      if (n_vals >= smax_pkg::DEPTH) begin
        v.status = smax_pkg::ST_FULL;
      end else begin
        record = (n_vals == 0) || (n_max == 0) ||
                 ($signed(value) > $signed(max_hist[n_max-1]));
        stk_vals[n_vals]  = value;
        stk_marks[n_vals] = record;
        if (record && n_max < smax_pkg::DEPTH) begin
          max_hist[n_max] = value;
          n_max++;
        end
        n_vals++;
      end
    end else begin
      if (n_vals == 0) begin
        v.status = smax_pkg::ST_EMPTY;
      end else begin
        n_vals--;
        v.popped = stk_vals[n_vals];
        if (stk_marks[n_vals] && n_max > 0) n_max--;
      end
    end
    v.top   = (n_vals != 0) ? stk_vals[n_vals-1] : '0;
    v.maxv  = (n_vals != 0 && n_max != 0) ? max_hist[n_max-1] : '0;
    v.empty = (n_vals == 0);
    v.fill  = n_vals[smax_pkg::FILL_W-1:0];
    return v;
  endfunction

  // Value mix: extremes, a narrow band, ties with and steps above the current maximum, and random values.
  function automatic logic [smax_pkg::DATA_W-1:0] pick_value();
    logic [smax_pkg::DATA_W-1:0] cur_max;
    logic [smax_pkg::DATA_W-1:0] picked;
    cur_max = (n_vals != 0 && n_max != 0) ? max_hist[n_max-1] : '0;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: picked = 32'h8000_0000;
          1: picked = 32'h7FFF_FFFF;
          2: picked = 32'h0000_0000;
          3: picked = 32'hFFFF_FFFF;
          default: picked = 32'h0000_0001;
        endcase
      end
      1: picked = $urandom_range(0, 16) - 8;
      2: picked = cur_max;
      3: picked = cur_max + $urandom_range(1, 3);
      default: picked = $urandom;
    endcase
    return picked;
  endfunction

  function automatic void check_field(string name, logic [smax_pkg::DATA_W-1:0] want,
                                      logic [smax_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one beat with random gaps ahead of it, then record what it should produce.
  task automatic send_op(input logic mode, input logic [smax_pkg::DATA_W-1:0] value,
                         input logic typed, input stack_view_t want);
    stack_view_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_stack_op(mode, value);
    pending_views.push_back(typed ? want : predicted);
    if (mode == smax_pkg::MODE_PUSH) n_push++;
    else n_pop++;
    if (predicted.status == smax_pkg::ST_FULL) n_full++;
    if (predicted.status == smax_pkg::ST_EMPTY) n_empty++;
    if (n_vals > peak_fill) peak_fill = n_vals;
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    stack_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%0h, tuser %0d",
               out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("popped_value", want.popped, out_tdata[31:0]);
        check_field("top_value",    want.top,    out_tdata[63:32]);
        check_field("max_value",    want.maxv,   out_tdata[95:64]);
        check_field("is_empty",     32'(want.empty), 32'(out_tdata[96]));
        check_field("fill_count",   32'(want.fill),  32'(out_tdata[103:97]));
        check_field("status",       32'(want.status), 32'(out_tuser));
        n_checked++;
      end
    end
  end

  // Ends the run when neither side moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("stack_with_running_maximum_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int row;
    int n_random;
    int push_pct;
    int burst_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (row = 0; row < N_ROWS; row++) begin
      send_op(DIRECTED[row].mode, DIRECTED[row].value, DIRECTED[row].typed,
              DIRECTED[row].want);
    end

    // Random bursts: filling runs reach the full stack, draining runs hit empty pops.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: push_pct = 95;
        1: push_pct = 5;
        default: push_pct = 55;
      endcase
      burst_len = $urandom_range(20, 100);
      if (burst_len > RANDOM_ITEMS - n_random) burst_len = RANDOM_ITEMS - n_random;
      repeat (burst_len) begin
        // A long window without any idling on either side.
        idle_pct = (n_random >= 600 && n_random < 900) ? 0 : 20;
        if ($urandom_range(0, 99) < push_pct) begin
          send_op(smax_pkg::MODE_PUSH, pick_value(), 1'b0, NO_VIEW);
        end else begin
          send_op(smax_pkg::MODE_POP, $urandom, 1'b0, NO_VIEW);
        end
        n_random++;
      end
    end
    in_tvalid <= 1'b0;
    idle_pct = 20;

    // Drain, then give the block time to show any stray beat.
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d pushes and %0d pops; %0d refused as full, %0d refused as empty.",
             n_push, n_pop, n_full, n_empty);
    $display("Checked %0d result beats; deepest fill reached %0d of %0d.",
             n_checked, peak_fill, smax_pkg::DEPTH);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("stack_with_running_maximum_tb: clean");
    end else begin
      $display("stack_with_running_maximum_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/smax_pkg.sv
hw/rtl/smax_ctrl.sv
hw/rtl/smax_dp.sv
hw/rtl/stack_with_running_maximum.sv
dv/stack_with_running_maximum_tb.sv
